[rtl/core/ffa_pkg.sv]
// ffa_pkg: shared types, widths and codes for the first-fit unit allocator
// no dependencies; imported by ffa_engine, first_fit_unit_allocator, ffa_checker, ffa_scoreboard and the testbench
package ffa_pkg;

    localparam int MAX_UNITS = 1024;
    localparam int UNIT_AW   = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int UNIT_CW   = $clog2(MAX_UNITS + 1);
    localparam int SIZE_W    = 11;
    localparam int OWNER_W   = 16;
    localparam int VALUE_W   = 11;
    localparam int CFG_W     = 11;
    localparam int LIM_W     = (UNIT_CW > SIZE_W) ? UNIT_CW : SIZE_W;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(1024);
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    // register index, taken from paddr[2]
    localparam logic REG_MEMORY_UNITS = 1'b0;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        STATUS_ALLOC     = 2'd0,
        STATUS_NO_ROOM   = 2'd1,
        STATUS_FREE_DONE = 2'd2
    } status_t;

    typedef struct packed
    {
        opcode_t              opcode;
        logic [SIZE_W-1:0]    alloc_size;
        logic [OWNER_W-1:0]   owner_id;
    } req_item_t;

    typedef struct packed
    {
        status_t              status;
        logic [VALUE_W-1:0]   value;
    } rsp_item_t;

endpackage

[rtl/core/first_fit_unit_allocator.sv]
// first_fit_unit_allocator: top level with apb register and item channels; needs ffa_pkg, ffa_engine
// path to rsp_valid: a rejected item goes straight to the result, a free scans every unit,
//   an allocate with no room scans to the limit, one that fits scans to the run end then fills it
// one item at a time: the next is accepted once the result is parked in the output register
// reset: owner memory is cleared one unit a cycle over every unit, req_ready low meanwhile
module first_fit_unit_allocator
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ffa_pkg::PADDR_W-1:0] paddr,
    input  logic [ffa_pkg::PDATA_W-1:0] pwdata,
    output logic [ffa_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  ffa_pkg::req_item_t          req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output ffa_pkg::rsp_item_t          rsp
);
    import ffa_pkg::*;

    logic [CFG_W-1:0]  memory_units_reg;
    logic [LIM_W-1:0]  limit;
    logic              rsp_valid_reg;
    rsp_item_t         rsp_reg;
    logic              res_valid;
    logic              res_take;
    rsp_item_t         res;
    logic              cfg_write;

    // register file: memory_units at byte 0, written on the apb access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memory_units_reg <= CFG_RESET;
        end
        else if (cfg_write && paddr[2] == REG_MEMORY_UNITS)
        begin
            memory_units_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MEMORY_UNITS)
        begin
            prdata = PDATA_W'(memory_units_reg);
        end
    end

    // allocation limit saturates at the store size
    assign limit = (LIM_W'(memory_units_reg) > LIM_W'(MAX_UNITS))
                   ? LIM_W'(MAX_UNITS) : LIM_W'(memory_units_reg);

    ffa_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .limit     (limit),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // output register: the engine goes back to idle as soon as its result is parked here
    assign res_take  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= res_valid;
            if (res_valid)
            begin
                rsp_reg <= res;
            end
        end
    end

endmodule

[rtl/core/ffa_engine.sv]
// ffa_engine: unit-owner memory and the scan / fill / clear sequencer
// depends on ffa_pkg
module ffa_engine
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  ffa_pkg::req_item_t        req,
    input  logic [ffa_pkg::LIM_W-1:0] limit,
    output logic                      res_valid,
    input  logic                      res_take,
    output ffa_pkg::rsp_item_t        res
);
    import ffa_pkg::*;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [UNIT_AW-1:0]   addr_reg;
    logic                 chk_valid_reg;
    logic [UNIT_AW-1:0]   chk_addr_reg;
    logic [UNIT_AW-1:0]   last_reg;
    logic [UNIT_AW-1:0]   end_reg;
    opcode_t              op_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [OWNER_W-1:0]   id_reg;
    logic [SIZE_W-1:0]    run_reg;
    logic [VALUE_W-1:0]   count_reg;
    rsp_item_t            res_reg;
    logic [OWNER_W-1:0]   rdata_reg;

    logic [OWNER_W-1:0]   owner_mem [MAX_UNITS];

    logic                 mem_we;
    logic [UNIT_AW-1:0]   mem_waddr;
    logic [OWNER_W-1:0]   mem_wdata;
    logic                 accept;
    logic                 unit_free;
    logic                 free_hit;
    logic [SIZE_W-1:0]    run_inc;
    logic                 fit;
    logic                 chk_last;
    logic [UNIT_AW-1:0]   fit_start;
    logic [VALUE_W-1:0]   count_inc;
    logic                 bad_alloc;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    assign unit_free = (rdata_reg == '0);
    assign free_hit  = chk_valid_reg && (op_reg == OP_FREE) && (rdata_reg == id_reg);
    assign run_inc   = run_reg + SIZE_W'(1);
    assign fit       = chk_valid_reg && (op_reg == OP_ALLOC) && unit_free
                       && (run_inc == size_reg);
    assign chk_last  = (chk_addr_reg == last_reg);
    // run ends at the unit just checked
    assign fit_start = chk_addr_reg - UNIT_AW'(size_reg - SIZE_W'(1));
    assign count_inc = (count_reg == VALUE_MAX) ? count_reg : count_reg + VALUE_W'(1);
    assign bad_alloc = (req.alloc_size == '0) || (req.owner_id == '0)
                       || (LIM_W'(req.alloc_size) > limit);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = id_reg;
            end
            ST_SCAN:
            begin
                mem_we    = free_hit;
                mem_waddr = chk_addr_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            owner_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= owner_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    addr_reg <= addr_reg + UNIT_AW'(1);
                    if (addr_reg == UNIT_AW'(MAX_UNITS - 1))
                    begin
                        addr_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg        <= req.opcode;
                        size_reg      <= req.alloc_size;
                        id_reg        <= req.owner_id;
                        addr_reg      <= '0;
                        chk_valid_reg <= 1'b0;
                        run_reg       <= '0;
                        count_reg     <= '0;
                        if (req.opcode == OP_ALLOC)
                        begin
                            last_reg <= UNIT_AW'(limit - LIM_W'(1));
                        end
                        else
                        begin
                            last_reg <= UNIT_AW'(MAX_UNITS - 1);
                        end
                        if (req.opcode == OP_ALLOC && bad_alloc)
                        begin
                            res_reg   <= '{status: STATUS_NO_ROOM, value: '0};
                            state_reg <= ST_DONE;
                        end
                        else if (req.opcode == OP_FREE && req.owner_id == '0)
                        begin
                            res_reg   <= '{status: STATUS_FREE_DONE, value: '0};
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    addr_reg      <= addr_reg + UNIT_AW'(1);
                    chk_addr_reg  <= addr_reg;
                    chk_valid_reg <= 1'b1;
                    if (chk_valid_reg)
                    begin
                        if (op_reg == OP_ALLOC)
                        begin
                            run_reg <= unit_free ? run_inc : '0;
                            if (fit)
                            begin
                                addr_reg      <= fit_start;
                                end_reg       <= chk_addr_reg;
                                chk_valid_reg <= 1'b0;
                                res_reg       <= '{status: STATUS_ALLOC,
                                                   value: VALUE_W'(fit_start)};
                                state_reg     <= ST_FILL;
                            end
                            else if (chk_last)
                            begin
                                chk_valid_reg <= 1'b0;
                                res_reg       <= '{status: STATUS_NO_ROOM, value: '0};
                                state_reg     <= ST_DONE;
                            end
                        end
                        else
                        begin
                            if (free_hit)
                            begin
                                count_reg <= count_inc;
                            end
                            if (chk_last)
                            begin
                                chk_valid_reg <= 1'b0;
                                res_reg       <= '{status: STATUS_FREE_DONE,
                                                   value: free_hit ? count_inc : count_reg};
                                state_reg     <= ST_DONE;
                            end
                        end
                    end
                end
                ST_FILL:
                begin
                    addr_reg <= addr_reg + UNIT_AW'(1);
                    if (addr_reg == end_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (res_take)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/ffa_checker.sv]
// ffa_checker: port-level assertions for first_fit_unit_allocator, with its bind
// depends on ffa_pkg and first_fit_unit_allocator
module ffa_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ffa_pkg::PADDR_W-1:0] paddr,
    input  logic [ffa_pkg::PDATA_W-1:0] pwdata,
    input  logic [ffa_pkg::PDATA_W-1:0] prdata,
    input  logic                        pready,
    input  logic                        req_valid,
    input  logic                        req_ready,
    input  ffa_pkg::req_item_t          req,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  ffa_pkg::rsp_item_t          rsp
);
    import ffa_pkg::*;

    // a parked result holds until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken back to back");

    // a refused allocate reports zero
    a_no_room_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STATUS_NO_ROOM |-> rsp.value == '0)
        else $error("no-room result with nonzero value");

    // register readback follows the last write
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[2] == REG_MEMORY_UNITS)
        ##1 (paddr[2] == REG_MEMORY_UNITS)
        |-> prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))
        else $error("memory_units readback mismatch");

endmodule

bind first_fit_unit_allocator ffa_checker u_ffa_checker (.*);

[sim/ffa_checker.sv]
// ffa_scoreboard: watches the register port and both item channels of the allocator,
// keeps its own unit map and limit, predicts every response and compares it
// depends on ffa_pkg; instantiated by tb_first_fit_unit_allocator
module ffa_scoreboard
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffa_pkg::PADDR_W-1:0]   paddr,
    input  logic [ffa_pkg::PDATA_W-1:0]   pwdata,
    input  logic                          pready,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  ffa_pkg::req_item_t            req,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  ffa_pkg::rsp_item_t            rsp,
    output int unsigned                   mismatches,
    output int unsigned                   open_grants
);
    import ffa_pkg::*;

    // owner of every unit, zero is free
    bit [OWNER_W-1:0] owner_map [MAX_UNITS];
    bit [CFG_W-1:0]   units_cfg = CFG_RESET;
    rsp_item_t        grants_due [$];
    rsp_item_t        want;

    // first fit below the limit for allocate, release by owner over the whole map for free
    function automatic rsp_item_t grant_for(input req_item_t r);
        rsp_item_t   g;
        int unsigned lim;
        int unsigned run;
        int unsigned freed;
        int unsigned first;
        int unsigned u;
        int unsigned k;
        logic        placed;
        g.status = STATUS_NO_ROOM;
        g.value  = '0;
        lim      = (units_cfg > MAX_UNITS) ? MAX_UNITS : units_cfg;
        if (r.opcode == OP_FREE)
        begin
            freed = 0;
            if (r.owner_id != '0)
            begin
                for (u = 0; u < MAX_UNITS; u++)
                begin
                    if (owner_map[u] == r.owner_id)
                    begin
                        owner_map[u] = '0;
                        freed++;
                    end
                end
            end
            g.status = STATUS_FREE_DONE;
            g.value  = (freed > VALUE_MAX) ? VALUE_MAX : VALUE_W'(freed);
        end
        else if (r.alloc_size != '0 && r.owner_id != '0 && r.alloc_size <= lim)
        begin
            run    = 0;
            placed = 1'b0;
            for (u = 0; u < lim && !placed; u++)
            begin
                if (owner_map[u] == '0)
                begin
                    run++;
                    if (run == r.alloc_size)
                    begin
                        first = u + 1 - r.alloc_size;
                        for (k = first; k <= u; k++)
                            owner_map[k] = r.owner_id;
                        g.status = STATUS_ALLOC;
                        g.value  = VALUE_W'(first);
                        placed   = 1'b1;
                    end
                end
                else
                begin
                    run = 0;
                end
            end
        end
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int u = 0; u < MAX_UNITS; u++)
                owner_map[u] = '0;
            units_cfg = CFG_RESET;
            grants_due.delete();
            open_grants = 0;
        end
        else
        begin
            // register index sits above the byte offset
            if (psel && penable && pwrite && pready && paddr[2] == REG_MEMORY_UNITS)
                units_cfg = pwdata[CFG_W-1:0];
            if (req_valid && req_ready)
                grants_due.push_back(grant_for(req));
            if (rsp_valid && rsp_ready)
            begin
                if (grants_due.size() == 0)
                begin
                    $error("response item with none pending: status %0d, value %0d",
                           rsp.status, rsp.value);
                    mismatches++;
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.value !== want.value)
                    begin
                        $error("value: expected %0d, actual %0d", want.value, rsp.value);
                        mismatches++;
                    end
                end
            end
            open_grants = grants_due.size();
        end
    end

endmodule

[sim/tb_first_fit_unit_allocator.sv]
// tb_first_fit_unit_allocator: drives requests, responses and limit writes into the
// allocator, with ffa_scoreboard beside it predicting and comparing every response
// depends on ffa_pkg, first_fit_unit_allocator and ffa_scoreboard
module tb_first_fit_unit_allocator;
    import ffa_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               req_valid;
    logic               req_ready;
    req_item_t          req;
    logic               rsp_valid;
    logic               rsp_ready;
    rsp_item_t          rsp;
    int unsigned        mismatches;
    int unsigned        open_grants;

    // owners used by the random part, so that frees find units to release
    logic [OWNER_W-1:0] id_pool [8];

    always #6 clk = ~clk;

    first_fit_unit_allocator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    ffa_scoreboard checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .open_grants (open_grants)
    );

    function automatic req_item_t make_req(input opcode_t op, input int unsigned size,
                                           input int unsigned id);
        req_item_t r;
        r.opcode     = op;
        r.alloc_size = SIZE_W'(size);
        r.owner_id   = OWNER_W'(id);
        return r;
    endfunction

    // offer one item after a random gap, hold it until the block takes it
    // a gap of zero keeps valid high straight into the next item
    task automatic push_req(input req_item_t item, input logic calm);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!(req_valid && req_ready));
    endtask

    // limit write: only once every response has come back, setup then access phase
    task automatic set_units(input logic [CFG_W-1:0] units);
        @(negedge clk);
        req_valid <= 1'b0;
        wait (open_grants == 0);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({REG_MEMORY_UNITS, 2'b00});
        pwdata  <= PDATA_W'(units);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // response side: random stalls, quiet stretches, and one long hold-off so the
    // block sits on a finished result and has to back-pressure the request side
    // the hold-off outlasts a full scan plus a full fill
    initial
    begin : rsp_sink
        int unsigned stall_left;
        int unsigned taken;
        logic        calm_rx;
        rsp_ready  = 1'b0;
        stall_left = 0;
        taken      = 0;
        calm_rx    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                taken++;
                if (taken % 30 == 0)
                    calm_rx = ($urandom_range(0, 3) == 0);
                if (taken == 120)
                    stall_left = 3000;
                else
                    stall_left = calm_rx ? 0 : $urandom_range(0, 5);
            end
        end
    end

    initial
    begin : stimulus
        int unsigned        phase;
        int unsigned        n;
        int unsigned        roll;
        int unsigned        size;
        int unsigned        id;
        opcode_t            op;
        logic               calm_tx;
        logic [CFG_W-1:0]   units;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        req_valid = 1'b0;
        req       = '0;
        rst_n     = 1'b0;
        calm_tx   = 1'b0;
        id_pool[0] = 16'hFFFF;
        id_pool[1] = 16'h0001;
        for (int i = 2; i < 8; i++)
            id_pool[i] = $urandom_range(2, 65534);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, first under the reset limit of all units
        // the block clears its map after reset, so the first item waits on ready
        push_req(make_req(OP_ALLOC, 0, 5), 1'b0);          // zero size
        push_req(make_req(OP_ALLOC, 1, 0), 1'b0);          // owner zero on allocate
        push_req(make_req(OP_FREE, 0, 0), 1'b0);           // owner zero on free
        push_req(make_req(OP_ALLOC, 2047, 7), 1'b0);       // oversized, all size bits set
        push_req(make_req(OP_ALLOC, 1025, 7), 1'b1);       // one past the limit
        push_req(make_req(OP_ALLOC, 1024, 16'hFFFF), 1'b1); // whole map, all id bits set
        push_req(make_req(OP_ALLOC, 1, 2), 1'b0);          // map full
        push_req(make_req(OP_FREE, 0, 16'hFFFF), 1'b0);    // releases every unit
        push_req(make_req(OP_ALLOC, 3, 1), 1'b1);
        push_req(make_req(OP_ALLOC, 5, 2), 1'b1);
        push_req(make_req(OP_ALLOC, 2, 3), 1'b0);
        push_req(make_req(OP_FREE, 2047, 2), 1'b0);        // size ignored by free
        push_req(make_req(OP_ALLOC, 4, 4), 1'b0);          // first fit into the hole
        push_req(make_req(OP_ALLOC, 2, 5), 1'b0);          // leftover hole too short
        push_req(make_req(OP_FREE, 0, 9), 1'b0);           // owner with nothing
        // tight limit: only the one-unit hole is below it
        set_units(12);
        push_req(make_req(OP_ALLOC, 2, 6), 1'b0);
        push_req(make_req(OP_ALLOC, 1, 6), 1'b0);
        // no usable units at all, but free still reaches above the limit
        set_units(0);
        push_req(make_req(OP_ALLOC, 1, 6), 1'b0);
        push_req(make_req(OP_FREE, 0, 5), 1'b0);
        set_units(1);
        push_req(make_req(OP_ALLOC, 1, 8), 1'b0);
        push_req(make_req(OP_FREE, 0, 1), 1'b0);
        push_req(make_req(OP_ALLOC, 1, 8), 1'b0);
        // above the unit count, saturates to the whole map
        set_units(2047);
        push_req(make_req(OP_ALLOC, 1024, 9), 1'b0);
        push_req(make_req(OP_ALLOC, 1016, 9), 1'b0);

        // random part: eight phases of fifty items, each under its own limit
        // mostly small runs for pool owners, some frees, a little noise
        for (phase = 0; phase < 8; phase++)
        begin
            unique case (phase)
                0:       units = 1024;
                1:       units = 300;
                2:       units = 1;
                3:       units = 0;
                4:       units = 2047;
                5:       units = 64;
                6:       units = 1000;
                default: units = 1024;
            endcase
            set_units(units);
            for (n = 0; n < 50; n++)
            begin
                if (n % 25 == 0)
                    calm_tx = ($urandom_range(0, 3) == 0);
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    size = $urandom_range(1, 24);
                else if (roll < 92)
                    size = $urandom_range(25, 256);
                else if (roll < 97)
                    size = $urandom_range(0, 2047);
                else
                    size = 0;
                if ($urandom_range(0, 19) == 0)
                    id = $urandom_range(0, 65535);
                else
                    id = id_pool[$urandom_range(0, 7)];
                op = ($urandom_range(0, 99) < 30) ? OP_FREE : OP_ALLOC;
                push_req(make_req(op, size, id), calm_tx);
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        wait (open_grants == 0);
        // room for any stray response: one full scan plus the longest fill
        repeat (2 * MAX_UNITS + 16) @(posedge clk);
        if (mismatches == 0 && open_grants == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // timeout covers the worst case (full scan plus full fill on every item, longest gaps and
    // stalls, the clearing pass) four times over
    initial
    begin : watchdog
        #48_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[first_fit_unit_allocator.f]
rtl/core/ffa_pkg.sv
rtl/core/ffa_engine.sv
rtl/core/first_fit_unit_allocator.sv
rtl/core/ffa_checker.sv
sim/ffa_checker.sv
sim/tb_first_fit_unit_allocator.sv
